### hw/rtl/sector_interleave_map_builder_defines.svh
// Assertion macros shared by the sector interleave map builder RTL.
`ifndef SECTOR_INTERLEAVE_MAP_BUILDER_DEFINES_SVH
`define SECTOR_INTERLEAVE_MAP_BUILDER_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define SIMB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define SIMB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/simb_pkg.sv
// Shared types, constants and the microcode table of the sector map builder.
package simb_pkg;

  localparam int MAX_SECTORS_DEF = 32;

  localparam int SPT_W  = 6;   // sectors_per_track register
  localparam int SKEW_W = 5;   // track_skew register
  localparam int INTL_W = 4;   // interleave field
  localparam int IDX_W  = 5;   // slot_index field
  localparam int SECT_W = 6;   // sector_number field
  localparam int OPD_W  = 7;   // modulo operand: 31 + 31 + 15 fits
  localparam int APB_DW = 32;
  localparam int APB_AW = 4;

  localparam logic [SPT_W-1:0] SPT_RESET = SPT_W'(26);
  localparam logic [INTL_W-1:0] INTL_RESET = INTL_W'(1);

  typedef enum logic [1:0] {
    REG_SPT,
    REG_SKEW_EN,
    REG_SKEW,
    REG_NEG_BIAS
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_WAIT,
    ST_LDI,
    ST_RUNI,
    ST_LDB,
    ST_RUNB,
    ST_PLACE,
    ST_EMIT
  } step_t;

  typedef enum logic [2:0] {
    C_NONE,
    C_ACCEPT_NZ,
    C_MOD_DONE,
    C_DIRECT,
    C_PLACE_LAST,
    C_EMIT_LAST
  } cond_t;

  typedef enum logic {
    SRC_INTL,
    SRC_BIAS
  } mod_src_t;

  typedef enum logic {
    DST_IMOD,
    DST_SLOT
  } wb_dst_t;

  typedef struct packed {
    logic     in_rdy;
    logic     mod_ld;
    mod_src_t mod_src;
    logic     mod_wb;
    wb_dst_t  wb_dst;
    logic     bias_set;
    logic     place;
    logic     emit;
    cond_t    cond;
    logic     hold;
    step_t    target;
  } ucw_t;

  // Control store: one word per step.
  function automatic ucw_t simb_ucode(step_t s);
    ucw_t w;
    w = '0;
    case (s)
      ST_WAIT: begin
        w.in_rdy = 1'b1;
        w.cond   = C_ACCEPT_NZ;
        w.hold   = 1'b1;
        w.target = ST_LDI;
      end
      ST_LDI: begin
        w.mod_ld  = 1'b1;
        w.mod_src = SRC_INTL;
      end
      ST_RUNI: begin
        w.mod_wb = 1'b1;
        w.wb_dst = DST_IMOD;
        w.cond   = C_MOD_DONE;
        w.hold   = 1'b1;
        w.target = ST_LDB;
      end
      ST_LDB: begin
        w.mod_ld   = 1'b1;
        w.mod_src  = SRC_BIAS;
        w.bias_set = 1'b1;
        w.cond     = C_DIRECT;
        w.target   = ST_PLACE;
      end
      ST_RUNB: begin
        w.mod_wb = 1'b1;
        w.wb_dst = DST_SLOT;
        w.cond   = C_MOD_DONE;
        w.hold   = 1'b1;
        w.target = ST_PLACE;
      end
      ST_PLACE: begin
        w.place  = 1'b1;
        w.cond   = C_PLACE_LAST;
        w.hold   = 1'b1;
        w.target = ST_EMIT;
      end
      ST_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = C_EMIT_LAST;
        w.hold   = 1'b1;
        w.target = ST_WAIT;
      end
      default: begin
        w.cond   = C_NONE;
        w.hold   = 1'b1;
        w.target = ST_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

### hw/rtl/simb_in_if.sv
// Request channel: one word asks for one track's sector map.
interface simb_in_if;
  import simb_pkg::*;

  logic              valid;
  logic              ready;
  logic              interleave_given;
  logic [INTL_W-1:0] interleave;

  modport source (output valid, interleave_given, interleave, input ready);
  modport sink   (input valid, interleave_given, interleave, output ready);
endinterface

### hw/rtl/simb_out_if.sv
// Result channel: one word per slot of the track map.
interface simb_out_if;
  import simb_pkg::*;

  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  slot_index;
  logic [SECT_W-1:0] sector_number;
  logic              last;

  modport source (output valid, slot_index, sector_number, last, input ready);
  modport sink   (input valid, slot_index, sector_number, last, output ready);
endinterface

### hw/rtl/sector_interleave_map_builder.sv
// Top level: builds one track's interleaved sector map per request word.
// Per track with N sectors: accept, interleave remainder, start remainder when chained,
// N placements with P forward probes past taken slots (0 up to N*(N-1)/2), then N result
// words, plus output stalls. The remainder unit takes 7 subtract steps, then done; the
// place step probes one slot per cycle.
// rst_n (synchronous): registers to defaults, interleave 1, previous last slot 0; no map clear.
`include "sector_interleave_map_builder_defines.svh"

module sector_interleave_map_builder #(
  parameter int MAX_SECTORS = simb_pkg::MAX_SECTORS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  simb_in_if.sink                     in_ch,
  simb_out_if.source                  out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [simb_pkg::APB_AW-1:0] cfg_paddr,
  input  logic [simb_pkg::APB_DW-1:0] cfg_pwdata,
  output logic [simb_pkg::APB_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);
  import simb_pkg::*;

  localparam int SLOT_W = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;
  localparam int CNT_W  = $clog2(MAX_SECTORS + 1);
  localparam int SW1    = SLOT_W + 1;
  localparam int CW1    = CNT_W + 1;

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic [SPT_W-1:0]  spt_r;
  logic              skew_en_r;
  logic [SKEW_W-1:0] skew_r;
  logic              neg_bias_r;
  logic              cfg_wr;
  reg_idx_t          cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spt_r      <= SPT_RESET;
      skew_en_r  <= 1'b0;
      skew_r     <= '0;
      neg_bias_r <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SPT:      spt_r      <= cfg_pwdata[SPT_W-1:0];
        REG_SKEW_EN:  skew_en_r  <= cfg_pwdata[0];
        REG_SKEW:     skew_r     <= cfg_pwdata[SKEW_W-1:0];
        REG_NEG_BIAS: neg_bias_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SPT:      cfg_prdata = APB_DW'(spt_r);
      REG_SKEW_EN:  cfg_prdata = APB_DW'(skew_en_r);
      REG_SKEW:     cfg_prdata = APB_DW'(skew_r);
      REG_NEG_BIAS: cfg_prdata = APB_DW'(neg_bias_r);
      default:      cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------
  // Sequencer: step counter plus control store lookup
  // ---------------------------------------------------------------
  step_t step_r, step_nxt;
  ucw_t  cw;
  logic  cond_hit;

  // Datapath state
  logic [INTL_W-1:0]      cur_intl_r, cur_intl_nxt;
  logic [IDX_W-1:0]       prev_r, prev_nxt;
  logic [CNT_W-1:0]       n_r, n_nxt;
  logic                   chained_r, chained_nxt;
  logic [MAX_SECTORS-1:0] taken_r, taken_nxt;
  logic [SLOT_W-1:0]      slot_r, slot_nxt;
  logic [SLOT_W-1:0]      imod_r, imod_nxt;
  logic [CNT_W-1:0]       i_r, i_nxt;
  logic [SLOT_W-1:0]      e_r, e_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // Output payload and map memory
  logic [IDX_W-1:0]  out_slot_r;
  logic [SECT_W-1:0] out_sector_r;
  logic              out_last_r;
  logic [SECT_W-1:0] map_mem [MAX_SECTORS];

  // Combinational helpers
  logic              in_acc;
  logic [CNT_W-1:0]  n_sat;
  logic              slot_busy;
  logic              place_en;
  logic              place_last;
  logic              emit_fire;
  logic              emit_last;
  logic [CW1-1:0]    e_plus1;
  logic [SW1-1:0]    slot_w1;
  logic [SW1-1:0]    n_w1;
  logic [SW1-1:0]    step_sum;
  logic [SW1-1:0]    probe_sum;
  logic [SLOT_W-1:0] slot_stepped;
  logic [SLOT_W-1:0] slot_probed;
  logic [OPD_W-1:0]  bias_opd;
  logic [OPD_W-1:0]  mod_opd;
  logic [OPD_W-1:0]  mod_rem;
  logic              mod_done;

  // Fetch the control word for the current step
  always_comb begin
    cw = simb_ucode(step_r);
  end

  // Clamp N to the map depth
  always_comb begin
    if ({1'b0, spt_r} > 7'(MAX_SECTORS)) begin
      n_sat = CNT_W'(MAX_SECTORS);
    end else begin
      n_sat = CNT_W'(spt_r);
    end
  end

  assign in_acc     = in_ch.valid && cw.in_rdy;
  assign slot_busy  = taken_r[slot_r];
  assign place_en   = cw.place && !slot_busy;
  assign place_last = place_en && (i_r == n_r);
  assign emit_fire  = cw.emit && (!out_valid_r || out_ch.ready);
  assign e_plus1    = CW1'(e_r) + CW1'(1);
  assign emit_last  = e_plus1 == CW1'(n_r);

  // Slot arithmetic: both addends stay below N, so one subtract folds the sum
  assign slot_w1      = SW1'(slot_r);
  assign n_w1         = SW1'(n_r);
  assign step_sum     = slot_w1 + SW1'(imod_r);
  assign slot_stepped = (step_sum >= n_w1) ? SLOT_W'(step_sum - n_w1) : SLOT_W'(step_sum);
  assign probe_sum    = slot_w1 + SW1'(1);
  assign slot_probed  = (probe_sum == n_w1) ? '0 : SLOT_W'(probe_sum);

  // Chained start: previous last slot plus skew plus interleave, reduced mod N
  assign bias_opd = OPD_W'(prev_r) + OPD_W'(skew_r) + OPD_W'(cur_intl_r);
  assign mod_opd  = (cw.mod_src == SRC_BIAS) ? bias_opd : OPD_W'(cur_intl_r);

  simb_mod_unit #(
    .CNT_W (CNT_W)
  ) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .ld    (cw.mod_ld),
    .opd   (mod_opd),
    .div   (n_r),
    .rem   (mod_rem),
    .done  (mod_done)
  );

  // Next step: jump on a hit, else hold or advance
  always_comb begin
    case (cw.cond)
      C_NONE:       cond_hit = 1'b0;
      C_ACCEPT_NZ:  cond_hit = in_acc && (n_sat != '0);
      C_MOD_DONE:   cond_hit = mod_done;
      C_DIRECT:     cond_hit = !chained_r;
      C_PLACE_LAST: cond_hit = place_last;
      C_EMIT_LAST:  cond_hit = emit_fire && emit_last;
      default:      cond_hit = 1'b0;
    endcase
    if (cond_hit) begin
      step_nxt = cw.target;
    end else if (cw.hold) begin
      step_nxt = step_r;
    end else begin
      step_nxt = step_t'(step_r + 3'd1);
    end
  end

  // Datapath updates driven by the control word
  always_comb begin
    cur_intl_nxt  = cur_intl_r;
    prev_nxt      = prev_r;
    n_nxt         = n_r;
    chained_nxt   = chained_r;
    taken_nxt     = taken_r;
    slot_nxt      = slot_r;
    imod_nxt      = imod_r;
    i_nxt         = i_r;
    e_nxt         = e_r;
    out_valid_nxt = out_valid_r;

    // Latch the request; a given interleave loads even for an empty track
    if (in_acc) begin
      if (in_ch.interleave_given) begin
        cur_intl_nxt = in_ch.interleave;
      end
      n_nxt       = n_sat;
      chained_nxt = !in_ch.interleave_given && skew_en_r;
      taken_nxt   = '0;
      i_nxt       = CNT_W'(1);
    end

    // Unchained start: slot 0 in negative-bias mode, else interleave mod N
    if (cw.bias_set && !chained_r) begin
      slot_nxt = neg_bias_r ? '0 : imod_r;
    end

    if (cw.mod_wb && mod_done) begin
      case (cw.wb_dst)
        DST_IMOD: imod_nxt = SLOT_W'(mod_rem);
        DST_SLOT: slot_nxt = SLOT_W'(mod_rem);
        default: ;
      endcase
    end

    // Place one sector, or probe one slot forward
    if (cw.place) begin
      if (slot_busy) begin
        slot_nxt = slot_probed;
      end else begin
        taken_nxt[slot_r] = 1'b1;
        if (place_last) begin
          prev_nxt = IDX_W'(slot_r);
          e_nxt    = '0;
        end else begin
          i_nxt    = i_r + CNT_W'(1);
          slot_nxt = slot_stepped;
        end
      end
    end

    // Output register: drop on take, refill on an emit step
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit_fire) begin
      out_valid_nxt = 1'b1;
      e_nxt         = SLOT_W'(e_plus1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= ST_WAIT;
      cur_intl_r  <= INTL_RESET;
      prev_r      <= '0;
      n_r         <= '0;
      chained_r   <= 1'b0;
      taken_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      cur_intl_r  <= cur_intl_nxt;
      prev_r      <= prev_nxt;
      n_r         <= n_nxt;
      chained_r   <= chained_nxt;
      taken_r     <= taken_nxt;
      out_valid_r <= out_valid_nxt;
    end
    slot_r <= slot_nxt;
    imod_r <= imod_nxt;
    i_r    <= i_nxt;
    e_r    <= e_nxt;
  end

  // Map memory: write on placement, registered read straight into the output word
  always_ff @(posedge clk) begin
    if (place_en) begin
      map_mem[slot_r] <= SECT_W'(i_r);
    end
    if (emit_fire) begin
      out_sector_r <= map_mem[e_r];
      out_slot_r   <= IDX_W'(e_r);
      out_last_r   <= emit_last;
    end
  end

  assign in_ch.ready          = cw.in_rdy;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.slot_index    = out_slot_r;
  assign out_ch.sector_number = out_sector_r;
  assign out_ch.last          = out_last_r;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  `SIMB_ASSERT_NOW(a_place_count, step_r == ST_PLACE, (i_r != '0) && (i_r <= n_r), "sector count out of range while placing")
  `SIMB_ASSERT_NOW(a_place_slot, step_r == ST_PLACE, slot_w1 < n_w1, "slot outside track while placing")
  `SIMB_ASSERT_NOW(a_mod_range, (step_r == ST_RUNB) && mod_done, mod_rem < OPD_W'(n_r), "remainder not below sector count")
  `SIMB_ASSERT_NEXT(a_emit_end, emit_fire && emit_last, step_r == ST_WAIT, "sequencer did not return to wait after last word")

endmodule

### hw/rtl/simb_mod_unit.sv
// Multi-cycle restoring remainder unit, one quotient bit per cycle.
module simb_mod_unit #(
  parameter int CNT_W = 6
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       ld,
  input  logic [simb_pkg::OPD_W-1:0] opd,
  input  logic [CNT_W-1:0]           div,
  output logic [simb_pkg::OPD_W-1:0] rem,
  output logic                       done
);
  import simb_pkg::*;

  localparam int WIDE_W = OPD_W + CNT_W;
  localparam int K_W    = $clog2(OPD_W);

  logic [OPD_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  div_r, div_nxt;
  logic [K_W-1:0]    k_r, k_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [WIDE_W-1:0] shifted;
  logic [WIDE_W-1:0] rem_wide;

  assign shifted  = WIDE_W'(div_r) << k_r;
  assign rem_wide = WIDE_W'(rem_r);

  always_comb begin
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    k_nxt    = k_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (ld) begin
      rem_nxt  = opd;
      div_nxt  = div;
      k_nxt    = K_W'(OPD_W - 1);
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      if (rem_wide >= shifted) begin
        rem_nxt = OPD_W'(rem_wide - shifted);
      end
      if (k_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        k_nxt = k_r - K_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    k_r   <= k_nxt;
  end

  assign rem  = rem_r;
  assign done = done_r;
endmodule
